/* sv/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg: shared types, constants and rounding for the bezier path sampler
// coordinate width CW sets the field widths; sequencer states and codes
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int CW = 24;

  typedef struct packed {
    logic signed [CW-1:0] anchor_x;
    logic signed [CW-1:0] anchor_y;
    logic signed [CW-1:0] handle_in_x;
    logic signed [CW-1:0] handle_in_y;
    logic signed [CW-1:0] handle_out_x;
    logic signed [CW-1:0] handle_out_y;
    logic                 end_of_path;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] sample_x;
    logic signed [CW-1:0] sample_y;
    logic                 run_last;
  } out_item_t;

  localparam logic CFG_CLOSED  = 1'b0;
  localparam logic CFG_SAMPLES = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,   // wait for an item
    S_DIV,    // bit-serial t = (j<<16)/n
    S_U2,     // u*u
    S_T2,     // t*t
    S_W0,     // u2*u -> w0
    S_W1,     // u2*t -> 3x -> w1
    S_W2,     // t2*u -> 3x -> w2
    S_W3,     // t2*t -> w3
    S_ACC,    // four weight*point products per axis
    S_EMIT,   // hold result until taken
    S_ANCHOR  // open path end: emit anchor
  } st_t;

  // round to nearest (half up), shift by 16, saturate to CW bits
  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [CW+19:0] s);
    logic signed [CW+19:0] b;
    logic signed [CW+3:0]  q;
    b = s + (CW+20)'(32768);
    q = b[CW+19:16];
    if (q > (CW+4)'(signed'({1'b0, {(CW-1){1'b1}}})))
      rnd_sat = {1'b0, {(CW-1){1'b1}}};
    else if (q < -(CW+4)'(signed'({1'b0, {(CW-1){1'b1}}})) - (CW+4)'(1))
      rnd_sat = {1'b1, {(CW-1){1'b0}}};
    else
      rnd_sat = q[CW-1:0];
  endfunction

endpackage

/* sv/bps_mul.sv */
// ----------------------------------------------------------------------------
// bps_mul: shared registered multiplier
// 17-bit unsigned weight by signed coordinate or 17x17 unsigned, one product
// ----------------------------------------------------------------------------
module bps_mul (
  input  logic                     clk,
  input  logic        [16:0]       a,
  input  logic signed [25:0]       b,
  output logic signed [43:0]       p_r
);
  import bps_pkg::*;

  logic signed [43:0] p_nxt;

  assign p_nxt = 44'(signed'({1'b0, a})) * 44'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

/* sv/bps_div.sv */
// ----------------------------------------------------------------------------
// bps_div: restoring divider for t = (j << 16) / n
// one quotient bit per cycle in each division
// ----------------------------------------------------------------------------
module bps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [4:0]  j,
  input  logic [5:0]  n,
  output logic        done,
  output logic [16:0] q
);
  import bps_pkg::*;

  logic [20:0] num_r, num_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [6:0]  trial;

  assign trial = {rem_r, num_r[20]};

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = {j, 16'd0};
      rem_nxt  = '0;
      cnt_nxt  = 5'd21;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, n}) begin
        rem_nxt = 6'(trial - {1'b0, n});
        num_nxt = {num_r[19:0], 1'b1};
      end else begin
        rem_nxt = trial[5:0];
        num_nxt = {num_r[19:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done = !busy_r && !start;
  assign q    = num_r[16:0];

endmodule

/* sv/bezier_path_sampler_top.sv */
// ----------------------------------------------------------------------------
// bezier_path_sampler_top: cubic bezier path flattening to uniform samples
// ----------------------------------------------------------------------------
// sequence: each sample runs the divide, the squares u*u and t*t, the weight
//   products and the weight*point products, then holds in emit until taken
// a path point yields up to 2*N segment samples (N the effective count),
//   or its segment samples and then its anchor at an open path end; a point
//   that only starts a path emits nothing, or only its anchor if it also ends
//   an open path; no new point is taken until the last one and its output are done
// the sample rate is set by the single shared multiplier and bit-serial divider
// reset: synchronous active low; config back to open path, 8 samples
module bezier_path_sampler_top #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bps_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bps_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data
);
  import bps_pkg::*;

  // configuration
  logic       closed_r;
  logic [5:0] nsamp_r;
  logic [5:0] ncnt;   // effective count

  // path state
  logic                 started_r;
  logic signed [CW-1:0] fax_r, fay_r, fhx_r, fhy_r;
  logic signed [CW-1:0] pax_r, pay_r, phx_r, phy_r;
  in_item_t             cur_r;

  // sequencer
  st_t        st_r, st_nxt;
  logic       seg2_r;       // working on the closing segment
  logic [4:0] j_r;
  logic [16:0] t_r, u_r;
  logic [33:0] u2_r, t2_r;
  logic [16:0] w_r [4];
  logic [2:0]  k_r;         // product index in accumulate step
  logic signed [CW+19:0] sx_r, sy_r;
  out_item_t   obuf_r;
  logic        ovld_r;

  logic        div_start, div_done;
  logic [4:0]  div_j;       // sample index handed to the divider at start
  logic [16:0] div_q;
  logic [16:0] ma;
  logic signed [25:0] mb;
  logic signed [43:0] mp;
  logic [50:0] wide;

  assign ncnt = (nsamp_r == 6'd0) ? 6'd1 :
                (nsamp_r > 6'(MAX_SAMPLES)) ? 6'(MAX_SAMPLES) : nsamp_r;

  bps_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .j(div_j), .n(ncnt),
    .done(div_done), .q(div_q)
  );

  bps_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(mp));

  // segment control points for the current segment
  logic signed [CW-1:0] cpx [4];
  logic signed [CW-1:0] cpy [4];
  always_comb begin
    if (!seg2_r) begin
      cpx[0] = pax_r;             cpy[0] = pay_r;
      cpx[1] = phx_r;             cpy[1] = phy_r;
      cpx[2] = cur_r.handle_in_x; cpy[2] = cur_r.handle_in_y;
      cpx[3] = cur_r.anchor_x;    cpy[3] = cur_r.anchor_y;
    end else begin
      cpx[0] = cur_r.anchor_x;     cpy[0] = cur_r.anchor_y;
      cpx[1] = cur_r.handle_out_x; cpy[1] = cur_r.handle_out_y;
      cpx[2] = fhx_r;              cpy[2] = fhy_r;
      cpx[3] = fax_r;              cpy[3] = fay_r;
    end
  end

  // multiplier operand selection: the weight steps feed 17-bit factors,
  // the accumulate step alternates x and y products of w[k]*P[k]
  // weight chain multiplies 34-bit squares cut into two 17-bit halves
  logic [1:0] wsub_r;   // sub step within weight states
  logic [33:0] acc34_r; // partial of a 34x17 weight product
  logic [2:0]  k_iss;   // product issued this cycle, one ahead once the pipe is full
  assign k_iss = (wsub_r == 2'd1) ? k_r + 3'd1 : k_r;
  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      S_U2: begin ma = u_r; mb = 26'(signed'({1'b0, u_r})); end
      S_T2: begin ma = t_r; mb = 26'(signed'({1'b0, t_r})); end
      S_W0, S_W1: begin
        ma = (st_r == S_W0) ? u_r : t_r;
        mb = wsub_r[0] ? 26'(u2_r[33:17]) : 26'(u2_r[16:0]);
      end
      S_W2, S_W3: begin
        ma = (st_r == S_W2) ? u_r : t_r;
        mb = wsub_r[0] ? 26'(t2_r[33:17]) : 26'(t2_r[16:0]);
      end
      S_ACC: begin
        ma = w_r[k_iss[2:1]];
        mb = k_iss[0] ? 26'(cpy[k_iss[2:1]]) : 26'(cpx[k_iss[2:1]]);
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // 34x17 product from two 17x17 partials: hi part shifted by 17
  assign wide = {17'd0, acc34_r} + {mp[33:0], 17'd0};

  logic accepted;
  logic has_seg1, want_seg2, want_anchor;
  assign accepted    = in_valid && !in_stall;
  assign in_stall    = (st_r != S_IDLE) || ovld_r;
  assign cfg_ready   = (st_r == S_IDLE) && !ovld_r;
  assign out_valid   = ovld_r;
  assign out_data    = obuf_r;
  assign want_seg2   = cur_r.end_of_path && closed_r && started_r;
  assign want_anchor = cur_r.end_of_path && !closed_r;
  assign div_start   = (st_r == S_IDLE && accepted && started_r) ||
                       (st_r == S_EMIT && !ovld_r && st_nxt == S_DIV);

  // next state
  logic samp_done;   // sample j was last of its segment
  assign samp_done = (j_r == 5'(ncnt - 6'd1));
  // a new segment starts at sample 0, otherwise the next sample
  assign div_j = (st_r == S_EMIT && !samp_done) ? j_r + 5'd1 : 5'd0;
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (accepted) begin
        if (started_r) st_nxt = S_DIV;
        else if (in_data.end_of_path && !closed_r) st_nxt = S_ANCHOR;
      end
      S_DIV:  if (div_done) st_nxt = S_U2;
      S_U2:   st_nxt = S_T2;
      S_T2:   st_nxt = S_W0;
      S_W0:   if (wsub_r == 2'd2) st_nxt = S_W1;
      S_W1:   if (wsub_r == 2'd2) st_nxt = S_W2;
      S_W2:   if (wsub_r == 2'd2) st_nxt = S_W3;
      S_W3:   if (wsub_r == 2'd2) st_nxt = S_ACC;
      S_ACC:  if (k_r == 3'd7 && wsub_r == 2'd1) st_nxt = S_EMIT;
      S_EMIT: if (!ovld_r) begin
        if (!samp_done) st_nxt = S_DIV;
        else if (!seg2_r && want_seg2) st_nxt = S_DIV;
        else if (want_anchor) st_nxt = S_ANCHOR;
        else st_nxt = S_IDLE;
      end
      S_ANCHOR: if (!ovld_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end
  assign has_seg1 = 1'b0;

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      closed_r  <= 1'b0;
      nsamp_r   <= 6'd8;
      started_r <= 1'b0;
      ovld_r    <= 1'b0;
      fax_r <= '0; fay_r <= '0; fhx_r <= '0; fhy_r <= '0;
      pax_r <= '0; pay_r <= '0; phx_r <= '0; phy_r <= '0;
      wsub_r <= '0;
      k_r    <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CLOSED) closed_r <= cfg_data[0];
        else nsamp_r <= cfg_data;
      end
      if (ovld_r && !out_stall) ovld_r <= 1'b0;

      case (st_r)
        S_IDLE: if (accepted) begin
          cur_r  <= in_data;
          seg2_r <= 1'b0;
          j_r    <= '0;
          if (!started_r) begin
            fax_r <= in_data.anchor_x;    fay_r <= in_data.anchor_y;
            fhx_r <= in_data.handle_in_x; fhy_r <= in_data.handle_in_y;
          end
          if (!started_r && !in_data.end_of_path) begin
            started_r <= 1'b1;
            pax_r <= in_data.anchor_x;     pay_r <= in_data.anchor_y;
            phx_r <= in_data.handle_out_x; phy_r <= in_data.handle_out_y;
          end else if (!started_r) begin
            pax_r <= in_data.anchor_x;     pay_r <= in_data.anchor_y;
            phx_r <= in_data.handle_out_x; phy_r <= in_data.handle_out_y;
          end
        end
        S_DIV: if (div_done) begin
          t_r <= div_q;
          u_r <= 17'h10000 - div_q;
        end
        S_U2: ;
        S_T2: u2_r <= mp[33:0];
        S_W0, S_W1, S_W2, S_W3: begin
          // sub 0: low half issued; 1: low product ready, hi issued;
          // 2: hi product ready
          if (st_r == S_W0 && wsub_r == 2'd0) t2_r <= mp[33:0];
          if (wsub_r == 2'd1) acc34_r <= mp[33:0];
          if (wsub_r == 2'd2) begin
            case (st_r)
              S_W0: w_r[0] <= wide[48:32];
              S_W1: w_r[1] <= 17'((51'(wide) * 51'd3) >> 32);
              S_W2: w_r[2] <= 17'((51'(wide) * 51'd3) >> 32);
              default: w_r[3] <= wide[48:32];
            endcase
            wsub_r <= '0;
            if (st_r == S_W3) begin
              k_r  <= '0;
              sx_r <= '0;
              sy_r <= '0;
            end
          end else begin
            wsub_r <= wsub_r + 2'd1;
          end
        end
        S_ACC: begin
          // wsub_r tracks one product in flight
          if (wsub_r == 2'd1) begin
            if (k_r[0]) sy_r <= sy_r + (CW+20)'(mp);
            else        sx_r <= sx_r + (CW+20)'(mp);
          end
          if (k_r == 3'd7 && wsub_r == 2'd1) begin
            wsub_r <= '0;
          end else if (wsub_r == 2'd0) begin
            wsub_r <= 2'd1;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_EMIT: begin
          if (!ovld_r && st_nxt != S_EMIT) begin
            j_r <= samp_done ? '0 : j_r + 5'd1;
            if (samp_done) seg2_r <= 1'b1;
            if (st_nxt == S_IDLE) begin
              started_r <= !cur_r.end_of_path;
              pax_r <= cur_r.anchor_x;     pay_r <= cur_r.anchor_y;
              phx_r <= cur_r.handle_out_x; phy_r <= cur_r.handle_out_y;
            end
          end
        end
        S_ANCHOR: if (!ovld_r) begin
          started_r <= 1'b0;
          pax_r <= cur_r.anchor_x;     pay_r <= cur_r.anchor_y;
          phx_r <= cur_r.handle_out_x; phy_r <= cur_r.handle_out_y;
        end
        default: ;
      endcase

      // result register load
      if (st_r == S_ACC && k_r == 3'd7 && wsub_r == 2'd1) begin
        ovld_r <= 1'b1;
      end else if (st_r == S_ANCHOR && !ovld_r) begin
        ovld_r <= 1'b1;
      end
    end
  end

  // output payload
  logic last_of_seg;
  assign last_of_seg = samp_done && !(!seg2_r && want_seg2) && !want_anchor;
  always_ff @(posedge clk) begin
    if (st_r == S_ACC && k_r == 3'd7 && wsub_r == 2'd1) begin
      obuf_r.sample_x <= rnd_sat(sx_r);
      obuf_r.sample_y <= rnd_sat(sy_r + (CW+20)'(mp));
      obuf_r.run_last <= last_of_seg;
    end else if (st_r == S_ANCHOR && !ovld_r) begin
      obuf_r.sample_x <= cur_r.anchor_x;
      obuf_r.sample_y <= cur_r.anchor_y;
      obuf_r.run_last <= 1'b1 | has_seg1;
    end
  end

endmodule

/* tb/sv/tb_bezier_path_sampler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bezier_path_sampler_top: self-checking bench for the bezier path sampler
// drives path points under random idling and stalls, predicts every sample
// in-bench and compares each output transaction with the oldest prediction
// ----------------------------------------------------------------------------
module tb_bezier_path_sampler_top;
  import bps_pkg::*;

  localparam int MAXS = 32;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [5:0] cfg_data;

  bezier_path_sampler_top #(.MAX_SAMPLES(MAXS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // idling knobs, percent of cycles
  int send_idle_pct;
  int recv_stall_pct;
  // long receiver hold-off, counted down by the stall process
  int hold_cycles;

  // predictor copy of configuration and path state
  logic closed_cfg;
  logic [5:0] count_cfg;
  logic path_open;
  logic signed [CW-1:0] first_ax, first_ay, first_hx, first_hy;
  logic signed [CW-1:0] prev_ax, prev_ay, prev_hx, prev_hy;

  out_item_t expected_samples[$];
  int mismatches;
  int orphans;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one bezier coordinate, rounded half up and saturated
  function automatic logic signed [CW-1:0] blend(input logic [16:0] w[4],
                                                 input logic signed [CW-1:0] p[4]);
    longint acc;
    longint q;
    acc = 0;
    for (int k = 0; k < 4; k++) acc += longint'(w[k]) * longint'(p[k]);
    acc += 64'sd32768;
    q = acc >>> 16;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[CW-1:0];
  endfunction

  task automatic push_segment(input int n, input logic signed [CW-1:0] px[4],
                              input logic signed [CW-1:0] py[4]);
    longint unsigned t, u;
    logic [16:0] w[4];
    out_item_t s;
    for (int j = 0; j < n; j++) begin
      t = (longint'(j) << 16) / n;
      u = 65536 - t;
      w[0] = 17'((u * u * u) >> 32);
      w[1] = 17'((3 * u * u * t) >> 32);
      w[2] = 17'((3 * u * t * t) >> 32);
      w[3] = 17'((t * t * t) >> 32);
      s.sample_x = blend(w, px);
      s.sample_y = blend(w, py);
      s.run_last = 1'b0;
      expected_samples = {expected_samples, s};
    end
  endtask

  task automatic predict_point(input in_item_t it);
    int n;
    int n_prior;
    logic signed [CW-1:0] px[4], py[4];
    out_item_t s;
    n = count_cfg;
    if (n < 1) n = 1;
    if (n > MAXS) n = MAXS;
    n_prior = expected_samples.size();
    if (!path_open) begin
      first_ax = it.anchor_x; first_ay = it.anchor_y;
      first_hx = it.handle_in_x; first_hy = it.handle_in_y;
    end else begin
      px = '{prev_ax, prev_hx, it.handle_in_x, it.anchor_x};
      py = '{prev_ay, prev_hy, it.handle_in_y, it.anchor_y};
      push_segment(n, px, py);
    end
    if (it.end_of_path) begin
      if (closed_cfg) begin
        if (path_open) begin
          px = '{it.anchor_x, it.handle_out_x, first_hx, first_ax};
          py = '{it.anchor_y, it.handle_out_y, first_hy, first_ay};
          push_segment(n, px, py);
        end
      end else begin
        s.sample_x = it.anchor_x;
        s.sample_y = it.anchor_y;
        s.run_last = 1'b0;
        expected_samples = {expected_samples, s};
      end
      path_open = 1'b0;
    end else begin
      path_open = 1'b1;
    end
    prev_ax = it.anchor_x; prev_ay = it.anchor_y;
    prev_hx = it.handle_out_x; prev_hy = it.handle_out_y;
    if (expected_samples.size() > n_prior)
      expected_samples[expected_samples.size()-1].run_last = 1'b1;
  endtask

  // send one path point; prediction made at acceptance
  // valid stays up until the next idle cycle or the next drain
  task automatic send_point(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_point(it);
  endtask

  // receiver stall generator, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker: each output transaction against the oldest prediction
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        orphans++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %h", out_data);
      end else begin
        e = expected_samples.pop_front();
        if (out_data.sample_x !== e.sample_x || out_data.sample_y !== e.sample_y ||
            out_data.run_last !== e.run_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     e.sample_x, e.sample_y, e.run_last,
                     out_data.sample_x, out_data.sample_y, out_data.run_last);
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    // anchorless first points can leave the sequencer briefly busy
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CLOSED) closed_cfg = val[0];
    else count_cfg = val;
    @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($urandom_range(4095)) - CW'(2048);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_point(input logic eop);
    in_item_t it;
    it.anchor_x = rand_coord(); it.anchor_y = rand_coord();
    it.handle_in_x = rand_coord(); it.handle_in_y = rand_coord();
    it.handle_out_x = rand_coord(); it.handle_out_y = rand_coord();
    it.end_of_path = eop;
    return it;
  endfunction

  function automatic in_item_t flat_point(input logic signed [CW-1:0] v, input logic eop);
    in_item_t it;
    it = '{v, v, v, v, v, v, eop};
    return it;
  endfunction

  // extremes, single-point paths, saturation, zero and oversized counts
  task automatic test_directed();
    localparam logic signed [CW-1:0] PMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] PMIN = {1'b1, {(CW-1){1'b0}}};
    in_item_t it;
    send_point(flat_point(PMAX, 1'b1));  // open single point: anchor only
    send_point(flat_point(PMIN, 1'b0));
    send_point(flat_point(PMAX, 1'b1));
    drain();
    write_reg(CFG_CLOSED, 6'd1);
    send_point(flat_point(PMIN, 1'b1));  // closed single point: nothing
    send_point(flat_point(PMAX, 1'b0));
    it = flat_point(PMAX, 1'b0);
    it.handle_in_x = PMIN;
    send_point(it);
    send_point(flat_point(PMIN, 1'b1));
    drain();
    write_reg(CFG_SAMPLES, 6'd0);        // zero treated as one
    send_point(rand_point(1'b0));
    send_point(rand_point(1'b1));
    drain();
    write_reg(CFG_SAMPLES, 6'd63);       // oversized clamps to the maximum
    send_point(rand_point(1'b0));
    send_point(rand_point(1'b1));
    drain();
    write_reg(CFG_CLOSED, 6'd0);
    write_reg(CFG_SAMPLES, 6'd32);
    send_point(flat_point('0, 1'b0));
    send_point(rand_point(1'b1));
    drain();
  endtask

  // random paths of 1..6 points, mostly small counts
  task automatic run_paths(input int points, input int s_idle, input int r_stall);
    int left;
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    left = 0;
    for (int i = 0; i < points; i++) begin
      if (left == 0) left = $urandom_range(1, 6);
      left--;
      send_point(rand_point(left == 0 || $urandom_range(19) == 0));
    end
  endtask

  task automatic test_random();
    logic [5:0] counts[4] = '{6'd1, 6'd3, 6'd5, 6'd2};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_CLOSED, 6'($urandom_range(1)));
      write_reg(CFG_SAMPLES, counts[ph]);
      case (ph)
        0: run_paths(30, 0, 0);
        1: run_paths(30, 82, 0);
        2: run_paths(30, 0, 82);
        default: run_paths(30, 19, 19);
      endcase
      drain();
    end
  endtask

  // long output hold-off while points keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 10;
    write_reg(CFG_SAMPLES, 6'd4);
    hold_cycles = 2000;
    run_paths(10, 0, 10);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CLOSED;
    cfg_data = '0;
    out_stall = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    orphans = 0;
    cycle_count = 0;
    closed_cfg = 1'b0;
    count_cfg = 6'd8;
    path_open = 1'b0;
    {first_ax, first_ay, first_hx, first_hy} = '0;
    {prev_ax, prev_ay, prev_hx, prev_hy} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/bps_pkg.sv
sv/bps_mul.sv
sv/bps_div.sv
sv/bezier_path_sampler_top.sv
tb/sv/tb_bezier_path_sampler_top.sv
